[rtl/iwst_pkg.sv]
// Shared types and constants for the in-flight write segment tracker.
// No dependencies; the controller, datapath, top level and bench files refer to this package.
`default_nettype none

package iwst_pkg;

	// Table sizes and the index and counter widths derived from them.
	localparam int SEG_SLOTS = 64;
	localparam int REQ_SLOTS = 32;
	localparam int SEG_W     = $clog2(SEG_SLOTS);
	localparam int REQ_W     = $clog2(REQ_SLOTS);
	localparam int CNT_W     = $clog2(SEG_SLOTS + 1);

	typedef enum logic [1:0] {
		OP_PUSH  = 2'd0,
		OP_POP   = 2'd1,
		OP_QUERY = 2'd2,
		OP_NOP   = 2'd3
	} op_t;

	typedef enum logic [2:0] {
		KIND_OUTDATED  = 3'd0,
		KIND_ASSIGNED  = 3'd1,
		KIND_POPPED    = 3'd2,
		KIND_SYNC      = 3'd3,
		KIND_NOT_FOUND = 3'd4,
		KIND_FULL      = 3'd5
	} kind_t;

	// One stored segment.
	typedef struct packed {
		logic [31:0]      chunk;
		logic [31:0]      first;
		logic [31:0]      limit;
		logic [REQ_W-1:0] owner;
	} seg_t;

	// Which owner entry the request tables are looked up at.
	typedef enum logic [1:0] {
		SEL_SCAN = 2'd0,
		SEL_BEST = 2'd1,
		SEL_HIT  = 2'd2,
		SEL_SEG  = 2'd3
	} own_sel_t;

	typedef enum logic [4:0] {
		ST_IDLE,
		ST_DISPATCH,
		ST_A_RD,
		ST_A_EV,
		ST_CHECK,
		ST_FULL,
		ST_B_RD,
		ST_B_EV,
		ST_B_SPL,
		ST_G_SCAN,
		ST_G_END,
		ST_G_EMIT,
		ST_STORE,
		ST_F_SCAN,
		ST_F_END,
		ST_NF,
		ST_Q_EMIT,
		ST_S_RD,
		ST_S_EV,
		ST_S_END,
		ST_S_NONE,
		ST_S_EMIT
	} state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic     in_ready;
		logic     scan_clr;
		logic     mem_rd;
		logic     a_eval;
		logic     b_eval;
		logic     b_split;
		logic     g_eval;
		logic     g_emit;
		logic     store_new;
		logic     f_eval;
		logic     s_eval;
		logic     s_emit;
		logic     emit_nf;
		logic     emit_full;
		logic     emit_sync;
		logic     free_hit;
		own_sel_t own_sel;
	} cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic in_valid;
		op_t  op;
		logic si_last;
		logic ri_last;
		logic push_ok;
		logic cut;
		logic found;
		logic split_need;
		logic cnt_zero;
		logic cnt_one;
		logic out_free;
	} sts_t;

endpackage

`default_nettype wire

[rtl/iwst_in_if.sv]
// Input channel of the segment tracker: valid/ready plus one request item.
// Depends on nothing.
`default_nettype none

interface iwst_in_if;
	logic        valid;
	logic        ready;
	logic [1:0]  op;
	logic [31:0] chunk;
	logic [63:0] sync_tag;
	logic [31:0] range_begin;
	logic [31:0] range_end;
	logic [31:0] target_id;

	modport source (output valid, op, chunk, sync_tag, range_begin, range_end, target_id,
		input ready);
	modport sink (input valid, op, chunk, sync_tag, range_begin, range_end, target_id,
		output ready);
endinterface

`default_nettype wire

[rtl/iwst_out_if.sv]
// Result channel of the segment tracker: valid/ready plus one result item.
// Depends on nothing.
`default_nettype none

interface iwst_out_if;
	logic        valid;
	logic        ready;
	logic [2:0]  kind;
	logic [31:0] req_id;
	logic [63:0] sync_out;
	logic [31:0] seg_first;
	logic [31:0] seg_limit;
	logic        last;

	modport source (output valid, kind, req_id, sync_out, seg_first, seg_limit, last,
		input ready);
	modport sink (input valid, kind, req_id, sync_out, seg_first, seg_limit, last,
		output ready);
endinterface

`default_nettype wire

[rtl/iwst_ctrl.sv]
// Sequencer of the segment tracker: walks push, pop and query through their scans.
// Depends on iwst_pkg.
`default_nettype none

module iwst_ctrl (
	input  wire                 clk,
	input  wire                 arst_n,
	input  iwst_pkg::sts_t      sts,
	output iwst_pkg::cmd_t      cmd
);

	iwst_pkg::state_t state_q;
	iwst_pkg::state_t state_nx;

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= iwst_pkg::ST_IDLE;
		end else begin
			state_q <= state_nx;
		end
	end

	// Next state.
	always_comb begin
		state_nx = state_q;
		case (state_q)
			iwst_pkg::ST_IDLE: begin
				if (sts.in_valid) state_nx = iwst_pkg::ST_DISPATCH;
			end
			iwst_pkg::ST_DISPATCH: begin
				case (sts.op)
					iwst_pkg::OP_PUSH: state_nx = iwst_pkg::ST_A_RD;
					iwst_pkg::OP_POP, iwst_pkg::OP_QUERY: state_nx = iwst_pkg::ST_F_SCAN;
					default: state_nx = iwst_pkg::ST_IDLE;
				endcase
			end
			iwst_pkg::ST_A_RD: state_nx = iwst_pkg::ST_A_EV;
			iwst_pkg::ST_A_EV: begin
				state_nx = sts.si_last ? iwst_pkg::ST_CHECK : iwst_pkg::ST_A_RD;
			end
			iwst_pkg::ST_CHECK: begin
				if (!sts.push_ok) state_nx = iwst_pkg::ST_FULL;
				else if (sts.cut) state_nx = iwst_pkg::ST_B_RD;
				else state_nx = iwst_pkg::ST_STORE;
			end
			iwst_pkg::ST_FULL: begin
				if (sts.out_free) state_nx = iwst_pkg::ST_IDLE;
			end
			iwst_pkg::ST_B_RD: state_nx = iwst_pkg::ST_B_EV;
			iwst_pkg::ST_B_EV: begin
				if (sts.split_need) state_nx = iwst_pkg::ST_B_SPL;
				else if (sts.si_last) state_nx = iwst_pkg::ST_G_SCAN;
				else state_nx = iwst_pkg::ST_B_RD;
			end
			iwst_pkg::ST_B_SPL: begin
				state_nx = sts.si_last ? iwst_pkg::ST_G_SCAN : iwst_pkg::ST_B_RD;
			end
			iwst_pkg::ST_G_SCAN: begin
				if (sts.ri_last) state_nx = iwst_pkg::ST_G_END;
			end
			iwst_pkg::ST_G_END: begin
				state_nx = sts.found ? iwst_pkg::ST_G_EMIT : iwst_pkg::ST_STORE;
			end
			iwst_pkg::ST_G_EMIT: begin
				if (sts.out_free) state_nx = iwst_pkg::ST_G_SCAN;
			end
			iwst_pkg::ST_STORE: begin
				if (sts.out_free) state_nx = iwst_pkg::ST_IDLE;
			end
			iwst_pkg::ST_F_SCAN: begin
				if (sts.ri_last) state_nx = iwst_pkg::ST_F_END;
			end
			iwst_pkg::ST_F_END: begin
				if (!sts.found) state_nx = iwst_pkg::ST_NF;
				else if (sts.op == iwst_pkg::OP_QUERY) state_nx = iwst_pkg::ST_Q_EMIT;
				else state_nx = iwst_pkg::ST_S_RD;
			end
			iwst_pkg::ST_NF, iwst_pkg::ST_Q_EMIT, iwst_pkg::ST_S_NONE: begin
				if (sts.out_free) state_nx = iwst_pkg::ST_IDLE;
			end
			iwst_pkg::ST_S_RD: state_nx = iwst_pkg::ST_S_EV;
			iwst_pkg::ST_S_EV: begin
				state_nx = sts.si_last ? iwst_pkg::ST_S_END : iwst_pkg::ST_S_RD;
			end
			iwst_pkg::ST_S_END: begin
				state_nx = sts.cnt_zero ? iwst_pkg::ST_S_NONE : iwst_pkg::ST_S_EMIT;
			end
			iwst_pkg::ST_S_EMIT: begin
				if (sts.out_free) state_nx = sts.cnt_one ? iwst_pkg::ST_IDLE : iwst_pkg::ST_S_RD;
			end
			default: state_nx = iwst_pkg::ST_IDLE;
		endcase
	end

	// Commands for each state.
	always_comb begin
		cmd = '0;
		case (state_q)
			iwst_pkg::ST_IDLE: cmd.in_ready = 1'b1;
			iwst_pkg::ST_DISPATCH: cmd.scan_clr = 1'b1;
			iwst_pkg::ST_A_RD, iwst_pkg::ST_B_RD, iwst_pkg::ST_S_RD: cmd.mem_rd = 1'b1;
			iwst_pkg::ST_A_EV: cmd.a_eval = 1'b1;
			iwst_pkg::ST_CHECK: cmd.scan_clr = 1'b1;
			iwst_pkg::ST_FULL: cmd.emit_full = sts.out_free;
			iwst_pkg::ST_B_EV: begin
				cmd.b_eval  = 1'b1;
				cmd.own_sel = iwst_pkg::SEL_SEG;
			end
			iwst_pkg::ST_B_SPL: begin
				cmd.b_split = 1'b1;
				cmd.own_sel = iwst_pkg::SEL_SEG;
			end
			iwst_pkg::ST_G_SCAN: begin
				cmd.g_eval  = 1'b1;
				cmd.own_sel = iwst_pkg::SEL_SCAN;
			end
			iwst_pkg::ST_G_EMIT: begin
				cmd.own_sel  = iwst_pkg::SEL_BEST;
				cmd.g_emit   = sts.out_free;
				cmd.scan_clr = sts.out_free;
			end
			iwst_pkg::ST_STORE: cmd.store_new = sts.out_free;
			iwst_pkg::ST_F_SCAN: begin
				cmd.f_eval  = 1'b1;
				cmd.own_sel = iwst_pkg::SEL_SCAN;
			end
			iwst_pkg::ST_F_END: cmd.scan_clr = sts.found;
			iwst_pkg::ST_NF: cmd.emit_nf = sts.out_free;
			iwst_pkg::ST_Q_EMIT: begin
				cmd.own_sel   = iwst_pkg::SEL_HIT;
				cmd.emit_sync = sts.out_free;
			end
			iwst_pkg::ST_S_EV: cmd.s_eval = 1'b1;
			iwst_pkg::ST_S_NONE: begin
				cmd.emit_nf  = sts.out_free;
				cmd.free_hit = sts.out_free;
			end
			iwst_pkg::ST_S_EMIT: begin
				cmd.s_emit   = sts.out_free;
				cmd.scan_clr = sts.out_free;
			end
			default: cmd = '0;
		endcase
	end

endmodule

`default_nettype wire

[rtl/iwst_datapath.sv]
// Datapath of the segment tracker: segment memory, request tables, scan
// counters and the result register. Depends on iwst_pkg and the channel interfaces.
`default_nettype none

module iwst_datapath (
	input  wire             clk,
	input  wire             arst_n,
	input  iwst_pkg::cmd_t  cmd,
	output iwst_pkg::sts_t  sts,
	iwst_in_if.sink         item,
	iwst_out_if.source      result
);

	localparam int SEG_SLOTS = iwst_pkg::SEG_SLOTS;
	localparam int REQ_SLOTS = iwst_pkg::REQ_SLOTS;
	localparam int SEG_W     = iwst_pkg::SEG_W;
	localparam int REQ_W     = iwst_pkg::REQ_W;
	localparam int CNT_W     = iwst_pkg::CNT_W;

	// Segment store: valid bits in flops, contents in a memory.
	logic [SEG_SLOTS-1:0] slot_valid_q;
	iwst_pkg::seg_t       seg_mem [SEG_SLOTS];
	iwst_pkg::seg_t       seg_rd_q;
	logic                 mem_we;
	logic [SEG_W-1:0]     mem_wa;
	iwst_pkg::seg_t       mem_wd;

	// Request tables.
	logic [REQ_SLOTS-1:0] own_valid_q;
	logic [REQ_SLOTS-1:0] touched_q;
	logic [31:0]          own_id_q   [REQ_SLOTS];
	logic [63:0]          own_sync_q [REQ_SLOTS];
	logic [CNT_W-1:0]     own_live_q [REQ_SLOTS];
	logic [31:0]          own_key_q  [REQ_SLOTS];

	// Latched request item.
	iwst_pkg::op_t        op_q;
	logic [31:0]          chunk_q;
	logic [63:0]          sync_q;
	logic [31:0]          b_q;
	logic [31:0]          e_q;
	logic [31:0]          tid_q;
	logic                 cut_q;
	logic [REQ_W-1:0]     fo_q;
	logic                 has_fo_q;

	// Scan state.
	logic [SEG_W-1:0]     si_q;
	logic [REQ_W-1:0]     ri_q;
	logic [CNT_W-1:0]     nfree_q;
	logic                 split_q;
	logic                 found_q;
	logic [CNT_W-1:0]     cnt_q;
	logic [REQ_W-1:0]     best_r_q;
	logic [31:0]          best_key_q;
	logic [SEG_W-1:0]     best_s_q;
	logic [31:0]          best_b_q;
	logic [31:0]          best_e_q;
	logic [REQ_W-1:0]     hit_q;
	logic [31:0]          id_cnt_q;

	// Result register.
	logic                 out_valid_q;
	iwst_pkg::kind_t      kind_q;
	logic [31:0]          req_id_q;
	logic [63:0]          sync_out_q;
	logic [31:0]          first_q;
	logic [31:0]          limit_q;
	logic                 last_q;

	logic                 accept;
	logic                 out_free;
	logic                 emit_any;
	logic [SEG_W-1:0]     free_s;
	logic [REQ_W-1:0]     free_r;
	logic                 any_free_r;
	logic [REQ_W-1:0]     own_idx;
	logic [CNT_W-1:0]     live_rd;
	logic [31:0]          key_rd;
	logic                 v_cur;
	logic                 match;
	logic                 b_front;
	logic                 b_kill;
	logic                 b_trim;
	logic                 b_back;
	logic                 split_need;
	logic                 g_cand;
	logic                 s_cand;

	assign accept   = item.valid && item.ready;
	assign out_free = !out_valid_q || result.ready;
	assign emit_any = cmd.g_emit || cmd.store_new || cmd.s_emit || cmd.emit_nf ||
		cmd.emit_full || cmd.emit_sync;

	// First free segment slot and first free request slot.
	always_comb begin
		free_s = '0;
		for (int k = SEG_SLOTS - 1; k >= 0; k--) begin
			if (!slot_valid_q[k]) free_s = SEG_W'(k);
		end
	end

	always_comb begin
		free_r = '0;
		for (int k = REQ_SLOTS - 1; k >= 0; k--) begin
			if (!own_valid_q[k]) free_r = REQ_W'(k);
		end
	end

	assign any_free_r = !(&own_valid_q);

	// Request table lookup address.
	always_comb begin
		case (cmd.own_sel)
			iwst_pkg::SEL_SCAN: own_idx = ri_q;
			iwst_pkg::SEL_BEST: own_idx = best_r_q;
			iwst_pkg::SEL_HIT:  own_idx = hit_q;
			iwst_pkg::SEL_SEG:  own_idx = seg_rd_q.owner;
			default:            own_idx = ri_q;
		endcase
	end

	assign live_rd = own_live_q[own_idx];
	assign key_rd  = own_key_q[own_idx];

	// Classification of the slot under the scan against the pushed range.
	assign v_cur      = slot_valid_q[si_q];
	assign match      = v_cur && (seg_rd_q.chunk == chunk_q);
	assign b_front    = match && (seg_rd_q.first >= b_q) && (seg_rd_q.first < e_q);
	assign b_kill     = b_front && !(seg_rd_q.limit > e_q);
	assign b_trim     = b_front && (seg_rd_q.limit > e_q);
	assign b_back     = match && (seg_rd_q.first < b_q) && (seg_rd_q.limit > b_q);
	assign split_need = b_back && (seg_rd_q.limit > e_q);
	assign g_cand     = own_valid_q[ri_q] && touched_q[ri_q] && (own_live_q[ri_q] == '0);
	assign s_cand     = v_cur && (seg_rd_q.owner == hit_q);

	// Segment memory write selection.
	always_comb begin
		mem_we = 1'b0;
		mem_wa = si_q;
		mem_wd = seg_rd_q;
		if (cmd.b_eval && b_trim) begin
			mem_we       = 1'b1;
			mem_wd.first = e_q;
		end else if (cmd.b_eval && b_back) begin
			mem_we       = 1'b1;
			mem_wd.limit = b_q;
		end else if (cmd.b_split) begin
			mem_we = 1'b1;
			mem_wa = free_s;
			mem_wd = '{chunk: chunk_q, first: e_q, limit: seg_rd_q.limit, owner: seg_rd_q.owner};
		end else if (cmd.store_new) begin
			mem_we = 1'b1;
			mem_wa = free_s;
			mem_wd = '{chunk: chunk_q, first: b_q, limit: e_q, owner: fo_q};
		end
	end

	// Segment memory: one write and one registered read per cycle.
	always_ff @(posedge clk) begin
		if (mem_we) seg_mem[mem_wa] <= mem_wd;
		if (cmd.mem_rd) seg_rd_q <= seg_mem[si_q];
	end

	// Request table contents.
	always_ff @(posedge clk) begin
		if (cmd.b_eval && b_kill) begin
			if (live_rd != '0) own_live_q[own_idx] <= live_rd - CNT_W'(1);
			if (!touched_q[own_idx] || (seg_rd_q.first > key_rd)) begin
				own_key_q[own_idx] <= seg_rd_q.first;
			end
		end
		if (cmd.b_split) own_live_q[own_idx] <= live_rd + CNT_W'(1);
		if (cmd.store_new) begin
			own_id_q[fo_q]   <= id_cnt_q;
			own_sync_q[fo_q] <= sync_q;
			own_live_q[fo_q] <= CNT_W'(1);
		end
	end

	// Valid bits, touch marks and the id counter.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_valid_q <= '0;
			own_valid_q  <= '0;
			touched_q    <= '0;
			id_cnt_q     <= '0;
		end else begin
			if (accept) touched_q <= '0;
			if (cmd.b_eval && b_kill) begin
				slot_valid_q[si_q]         <= 1'b0;
				touched_q[seg_rd_q.owner]  <= 1'b1;
			end
			if (cmd.b_split) slot_valid_q[free_s] <= 1'b1;
			if (cmd.g_emit) own_valid_q[best_r_q] <= 1'b0;
			if (cmd.store_new) begin
				own_valid_q[fo_q]    <= 1'b1;
				slot_valid_q[free_s] <= 1'b1;
				id_cnt_q             <= id_cnt_q + 32'd1;
			end
			if (cmd.s_emit) begin
				slot_valid_q[best_s_q] <= 1'b0;
				if (cnt_q == CNT_W'(1)) own_valid_q[hit_q] <= 1'b0;
			end
			if (cmd.free_hit) own_valid_q[hit_q] <= 1'b0;
		end
	end

	// Latch the accepted item; an empty range is stored as [begin, begin).
	always_ff @(posedge clk) begin
		if (accept) begin
			op_q     <= iwst_pkg::op_t'(item.op);
			chunk_q  <= item.chunk;
			sync_q   <= item.sync_tag;
			b_q      <= item.range_begin;
			e_q      <= (item.range_begin < item.range_end) ? item.range_end : item.range_begin;
			tid_q    <= item.target_id;
			cut_q    <= item.range_begin < item.range_end;
			fo_q     <= free_r;
			has_fo_q <= any_free_r;
		end
	end

	// Scan counters and running best candidate.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			si_q    <= '0;
			ri_q    <= '0;
			nfree_q <= '0;
			split_q <= 1'b0;
			found_q <= 1'b0;
			cnt_q   <= '0;
		end else begin
			if (accept) begin
				nfree_q <= '0;
				split_q <= 1'b0;
			end
			if (cmd.scan_clr) begin
				si_q    <= '0;
				ri_q    <= '0;
				found_q <= 1'b0;
				cnt_q   <= '0;
			end
			if (cmd.a_eval) begin
				if (!v_cur) nfree_q <= nfree_q + CNT_W'(1);
				else if (cut_q && split_need) split_q <= 1'b1;
				si_q <= si_q + SEG_W'(1);
			end
			if (cmd.b_eval && !split_need) si_q <= si_q + SEG_W'(1);
			if (cmd.b_split) si_q <= si_q + SEG_W'(1);
			if (cmd.g_eval) begin
				if (g_cand && (!found_q || (key_rd < best_key_q))) found_q <= 1'b1;
				ri_q <= ri_q + REQ_W'(1);
			end
			if (cmd.f_eval) begin
				if (!found_q && own_valid_q[ri_q] && (own_id_q[ri_q] == tid_q)) found_q <= 1'b1;
				ri_q <= ri_q + REQ_W'(1);
			end
			if (cmd.s_eval) begin
				if (s_cand) begin
					cnt_q   <= cnt_q + CNT_W'(1);
					found_q <= 1'b1;
				end
				si_q <= si_q + SEG_W'(1);
			end
		end
	end

	// Payload of the best candidate and of the found request.
	always_ff @(posedge clk) begin
		if (cmd.g_eval && g_cand && (!found_q || (key_rd < best_key_q))) begin
			best_key_q <= key_rd;
			best_r_q   <= ri_q;
		end
		if (cmd.f_eval && !found_q && own_valid_q[ri_q] && (own_id_q[ri_q] == tid_q)) begin
			hit_q <= ri_q;
		end
		if (cmd.s_eval && s_cand &&
			(!found_q || ({seg_rd_q.first, seg_rd_q.limit} < {best_b_q, best_e_q}))) begin
			best_s_q <= si_q;
			best_b_q <= seg_rd_q.first;
			best_e_q <= seg_rd_q.limit;
		end
	end

	// Result register control.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit_any) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Result register payload.
	always_ff @(posedge clk) begin
		if (emit_any) begin
			kind_q     <= iwst_pkg::KIND_NOT_FOUND;
			req_id_q   <= '0;
			sync_out_q <= '0;
			first_q    <= '0;
			limit_q    <= '0;
			last_q     <= 1'b1;
			if (cmd.g_emit) begin
				kind_q     <= iwst_pkg::KIND_OUTDATED;
				req_id_q   <= own_id_q[own_idx];
				sync_out_q <= own_sync_q[own_idx];
				last_q     <= 1'b0;
			end else if (cmd.store_new) begin
				kind_q   <= iwst_pkg::KIND_ASSIGNED;
				req_id_q <= id_cnt_q;
			end else if (cmd.s_emit) begin
				kind_q   <= iwst_pkg::KIND_POPPED;
				req_id_q <= tid_q;
				first_q  <= best_b_q;
				limit_q  <= best_e_q;
				last_q   <= (cnt_q == CNT_W'(1));
			end else if (cmd.emit_sync) begin
				kind_q     <= iwst_pkg::KIND_SYNC;
				sync_out_q <= own_sync_q[own_idx];
			end else if (cmd.emit_full) begin
				kind_q <= iwst_pkg::KIND_FULL;
			end
		end
	end

	assign item.ready       = cmd.in_ready;
	assign result.valid     = out_valid_q;
	assign result.kind      = kind_q;
	assign result.req_id    = req_id_q;
	assign result.sync_out  = sync_out_q;
	assign result.seg_first = first_q;
	assign result.seg_limit = limit_q;
	assign result.last      = last_q;

	// Status back to the controller.
	always_comb begin
		sts.in_valid   = item.valid;
		sts.op         = op_q;
		sts.si_last    = (si_q == SEG_W'(SEG_SLOTS - 1));
		sts.ri_last    = (ri_q == REQ_W'(REQ_SLOTS - 1));
		sts.push_ok    = has_fo_q && (nfree_q >= (split_q ? CNT_W'(2) : CNT_W'(1)));
		sts.cut        = cut_q;
		sts.found      = found_q;
		sts.split_need = split_need;
		sts.cnt_zero   = (cnt_q == '0);
		sts.cnt_one    = (cnt_q == CNT_W'(1));
		sts.out_free   = out_free;
	end

	// A split piece always lands in a free slot.
	a_split_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.b_split |-> !slot_valid_q[free_s])
		else $error("split piece written over a live segment slot");

	// The new request takes the request slot found free at accept.
	a_store_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.store_new |-> !own_valid_q[fo_q])
		else $error("new request stored over a live request slot");

	// A popped segment is still live when it is returned.
	a_pop_live: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.s_emit |-> slot_valid_q[best_s_q])
		else $error("popped segment slot is not live");

	// A result is only loaded when the result register can take it.
	a_emit_room: assert property (@(posedge clk) disable iff (!arst_n)
		emit_any |-> out_free)
		else $error("result loaded while the previous one is still held");

endmodule

`default_nettype wire

[rtl/inflight_write_segment_tracker.sv]
// Top level of the in-flight write segment tracker: sequencer plus datapath.
// Depends on iwst_pkg, iwst_in_if, iwst_out_if, iwst_ctrl and iwst_datapath.
//
//   Channel  Dir  Transfer carries
//   item     in   op, chunk, sync_tag, range_begin, range_end, target_id
//   result   out  kind, req_id, sync_out, seg_first, seg_limit, last
//
// One item is worked on at a time; item.ready is high only while idle.
// Push: one pass over the segment memory, and a second one if the range is not
// empty (each reads then evaluates every slot, with one more step per split),
// then a request-table scan per outdated report plus one for the assigned id.
// Pop: a request-table scan to find the request, then a segment pass per segment.
// Query: a request-table scan.
// arst_n clears all valid bits and the id counter; no clearing pass is needed.
// A held result stalls only the sequencer step that would load the next one.
`default_nettype none

module inflight_write_segment_tracker (
	input  wire         clk,
	input  wire         arst_n,
	iwst_in_if.sink     item,
	iwst_out_if.source  result
);

	iwst_pkg::cmd_t cmd;
	iwst_pkg::sts_t sts;

	iwst_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.sts    (sts),
		.cmd    (cmd)
	);

	iwst_datapath u_datapath (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.sts    (sts),
		.item   (item),
		.result (result)
	);

endmodule

`default_nettype wire

[bench/iwst_tracker_checker.sv]
// Checker for the in-flight write segment tracker: watches both channels,
// predicts the result items of each accepted request and compares them.
// Depends on iwst_pkg, iwst_in_if and iwst_out_if.
`timescale 1ns / 100ps

module iwst_tracker_checker (
	input  wire  clk,
	input  wire  arst_n,
	iwst_in_if   item,
	iwst_out_if  result,
	output int   fail_count,
	output int   pending_count,
	output int   checked_count
);

	localparam int SEG_SLOTS = iwst_pkg::SEG_SLOTS;
	localparam int REQ_SLOTS = iwst_pkg::REQ_SLOTS;

	typedef struct {
		iwst_pkg::kind_t kind;
		logic [31:0]     req_id;
		logic [63:0]     sync_out;
		logic [31:0]     seg_first;
		logic [31:0]     seg_limit;
		logic            last;
	} outcome_t;

	outcome_t    outcome_q[$];

	// Shadow copy of the segment and request tables.
	logic        seg_live [SEG_SLOTS];
	logic [31:0] seg_chunk[SEG_SLOTS];
	logic [31:0] seg_first[SEG_SLOTS];
	logic [31:0] seg_limit[SEG_SLOTS];
	int          seg_owner[SEG_SLOTS];
	logic        req_live [REQ_SLOTS];
	logic [31:0] req_id   [REQ_SLOTS];
	logic [63:0] req_sync [REQ_SLOTS];
	int          req_count[REQ_SLOTS];
	logic [31:0] next_id;

	function automatic void add_outcome(iwst_pkg::kind_t k, logic [31:0] id, logic [63:0] s,
		logic [31:0] f, logic [31:0] l);
		outcome_t o;
		o.kind = k;
		o.req_id = id;
		o.sync_out = s;
		o.seg_first = f;
		o.seg_limit = l;
		o.last = 1'b0;
		outcome_q.push_back(o);
	endfunction

	function automatic int lowest_free_seg();
		for (int i = 0; i < SEG_SLOTS; i++)
			if (!seg_live[i])
				return i;
		return -1;
	endfunction

	function automatic int lookup_request(logic [31:0] id);
		for (int r = 0; r < REQ_SLOTS; r++)
			if (req_live[r] && req_id[r] == id)
				return r;
		return -1;
	endfunction

	// A push cuts its range out of overlapping segments, retires emptied
	// requests in order of the highest begin they lost, then stores itself.
	function automatic void predict_push(logic [31:0] chunk, logic [63:0] sync,
		logic [31:0] b, logic [31:0] e);
		logic        touched[REQ_SLOTS];
		logic [31:0] lost_at[REQ_SLOTS];
		int          retired[$];
		logic        cut;
		logic        split;
		int          nfree;
		int          fo;
		int          j;
		int          k;
		logic [31:0] sb;
		logic [31:0] se;
		int          o;
		cut = b < e;
		split = 1'b0;
		nfree = 0;
		fo = -1;
		if (!cut)
			e = b;
		for (int i = 0; i < SEG_SLOTS; i++) begin
			if (!seg_live[i])
				nfree++;
			else if (cut && seg_chunk[i] == chunk && seg_first[i] < b && seg_limit[i] > e)
				split = 1'b1;
		end
		for (int r = 0; r < REQ_SLOTS; r++)
			if (fo < 0 && !req_live[r])
				fo = r;
		if (fo < 0 || nfree < (split ? 2 : 1)) begin
			add_outcome(iwst_pkg::KIND_FULL, '0, '0, '0, '0);
			return;
		end
		for (int r = 0; r < REQ_SLOTS; r++) begin
			touched[r] = 1'b0;
			lost_at[r] = '0;
		end
		if (cut) begin
			for (int i = 0; i < SEG_SLOTS; i++) begin
				if (!seg_live[i] || seg_chunk[i] != chunk)
					continue;
				sb = seg_first[i];
				se = seg_limit[i];
				o = seg_owner[i];
				if (sb >= b) begin
					if (sb >= e)
						continue;
					if (se > e) begin
						seg_first[i] = e;
					end else begin
						seg_live[i] = 1'b0;
						if (req_count[o] > 0)
							req_count[o]--;
						if (!touched[o] || sb > lost_at[o])
							lost_at[o] = sb;
						touched[o] = 1'b1;
					end
				end else begin
					if (se <= b)
						continue;
					seg_limit[i] = b;
					if (se > e) begin
						j = lowest_free_seg();
						if (j >= 0) begin
							seg_live[j] = 1'b1;
							seg_chunk[j] = chunk;
							seg_first[j] = e;
							seg_limit[j] = se;
							seg_owner[j] = o;
							req_count[o]++;
						end
					end
				end
			end
		end
		// Stable insertion by the highest begin each request lost.
		for (int r = 0; r < REQ_SLOTS; r++) begin
			if (req_live[r] && touched[r] && req_count[r] == 0) begin
				req_live[r] = 1'b0;
				k = retired.size();
				while (k > 0 && lost_at[retired[k-1]] > lost_at[r])
					k--;
				retired.insert(k, r);
			end
		end
		foreach (retired[i])
			if (i < 63)
				add_outcome(iwst_pkg::KIND_OUTDATED, req_id[retired[i]],
					req_sync[retired[i]], '0, '0);
		req_live[fo] = 1'b1;
		req_id[fo] = next_id;
		req_sync[fo] = sync;
		req_count[fo] = 1;
		j = lowest_free_seg();
		if (j >= 0) begin
			seg_live[j] = 1'b1;
			seg_chunk[j] = chunk;
			seg_first[j] = b;
			seg_limit[j] = e;
			seg_owner[j] = fo;
		end
		add_outcome(iwst_pkg::KIND_ASSIGNED, next_id, '0, '0, '0);
		next_id++;
	endfunction

	// A pop hands back every segment of the request in (begin, end) order.
	function automatic void predict_pop(logic [31:0] id);
		int order[$];
		int r;
		int k;
		r = lookup_request(id);
		if (r < 0) begin
			add_outcome(iwst_pkg::KIND_NOT_FOUND, '0, '0, '0, '0);
			return;
		end
		for (int i = 0; i < SEG_SLOTS; i++) begin
			if (seg_live[i] && seg_owner[i] == r) begin
				k = order.size();
				while (k > 0 && (seg_first[order[k-1]] > seg_first[i] ||
					(seg_first[order[k-1]] == seg_first[i] &&
					seg_limit[order[k-1]] > seg_limit[i])))
					k--;
				order.insert(k, i);
			end
		end
		foreach (order[i]) begin
			add_outcome(iwst_pkg::KIND_POPPED, id, '0, seg_first[order[i]],
				seg_limit[order[i]]);
			seg_live[order[i]] = 1'b0;
		end
		req_live[r] = 1'b0;
		if (order.size() == 0)
			add_outcome(iwst_pkg::KIND_NOT_FOUND, '0, '0, '0, '0);
	endfunction

	function automatic void predict_item(iwst_pkg::op_t op, logic [31:0] chunk,
		logic [63:0] sync, logic [31:0] b, logic [31:0] e, logic [31:0] id);
		int before_n;
		int r;
		before_n = outcome_q.size();
		case (op)
			iwst_pkg::OP_PUSH: predict_push(chunk, sync, b, e);
			iwst_pkg::OP_POP: predict_pop(id);
			iwst_pkg::OP_QUERY: begin
				r = lookup_request(id);
				if (r < 0)
					add_outcome(iwst_pkg::KIND_NOT_FOUND, '0, '0, '0, '0);
				else
					add_outcome(iwst_pkg::KIND_SYNC, '0, req_sync[r], '0, '0);
			end
			default: ;
		endcase
		if (outcome_q.size() > before_n)
			outcome_q[$].last = 1'b1;
	endfunction

	function automatic void note_failure(string what, outcome_t want);
		if (fail_count < 10) begin
			$display("%0t: %s: expected kind %0d id %0h sync %0h seg [%0h,%0h) last %0b,",
				$time, what, want.kind, want.req_id, want.sync_out, want.seg_first,
				want.seg_limit, want.last);
			$display("    got kind %0d id %0h sync %0h seg [%0h,%0h) last %0b",
				result.kind, result.req_id, result.sync_out, result.seg_first,
				result.seg_limit, result.last);
		end
		fail_count++;
	endfunction

	assign pending_count = outcome_q.size();

	// Input transfers feed the predictor; result transfers are compared.
	always @(posedge clk or negedge arst_n) begin
		outcome_t want;
		if (!arst_n) begin
			for (int i = 0; i < SEG_SLOTS; i++)
				seg_live[i] = 1'b0;
			for (int r = 0; r < REQ_SLOTS; r++)
				req_live[r] = 1'b0;
			next_id = '0;
			outcome_q.delete();
			fail_count = 0;
			checked_count = 0;
		end else begin
			if (item.valid && item.ready)
				predict_item(iwst_pkg::op_t'(item.op), item.chunk, item.sync_tag,
					item.range_begin, item.range_end, item.target_id);
			if (result.valid && result.ready) begin
				checked_count++;
				if (outcome_q.size() == 0) begin
					want = '{iwst_pkg::KIND_OUTDATED, '0, '0, '0, '0, 1'b0};
					note_failure("unexpected result", want);
				end else begin
					want = outcome_q.pop_front();
					if (result.kind != want.kind || result.req_id != want.req_id ||
						result.sync_out != want.sync_out || result.seg_first != want.seg_first ||
						result.seg_limit != want.seg_limit || result.last != want.last)
						note_failure("result mismatch", want);
				end
			end
		end
	end

endmodule

[bench/tb_inflight_write_segment_tracker.sv]
// Top of the segment tracker testbench: clock, reset, request stimulus,
// result back-pressure and verdict. Depends on iwst_pkg, both channel
// interfaces, the tracker and iwst_tracker_checker.
`timescale 1ns / 100ps

module tb_inflight_write_segment_tracker;

	localparam int IDLE_LIMIT = 40000;

	logic clk;
	logic arst_n;
	int   fail_count;
	int   pending_count;
	int   checked_count;
	int   idle_cycles;
	int   burst_left;
	int   pushes_sent;
	int   pops_sent;
	int   queries_sent;
	int   ready_mode;
	int   mode_left;
	int   phase;

	iwst_in_if  item_ch();
	iwst_out_if result_ch();

	inflight_write_segment_tracker DUT (
		.clk(clk),
		.arst_n(arst_n),
		.item(item_ch.sink),
		.result(result_ch.source)
	);

	iwst_tracker_checker u_checker (
		.clk(clk),
		.arst_n(arst_n),
		.item(item_ch),
		.result(result_ch),
		.fail_count(fail_count),
		.pending_count(pending_count),
		.checked_count(checked_count)
	);

	// Clock with a 4 ns period.
	initial clk = 1'b0;
	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Receiver stalls: phases of always ready, random stalls and a fixed pattern.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ready_mode <= 0;
			mode_left <= 0;
			phase <= 0;
			result_ch.ready <= 1'b0;
		end else begin
			phase <= phase + 1;
			if (mode_left == 0) begin
				ready_mode <= $urandom_range(0, 3);
				mode_left <= $urandom_range(20, 200);
			end else begin
				mode_left <= mode_left - 1;
			end
			case (ready_mode)
				0: result_ch.ready <= 1'b1;
				1: result_ch.ready <= ($urandom_range(0, 3) != 0);
				2: result_ch.ready <= (phase % 3 == 0);
				default: result_ch.ready <= ($urandom_range(0, 7) == 0);
			endcase
		end
	end

	// Watchdog over cycles without any transfer.
	always @(posedge clk) begin
		if (!arst_n || (item_ch.valid && item_ch.ready) || (result_ch.valid && result_ch.ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("Timeout after %0d cycles without a transfer", IDLE_LIMIT);
			$display("Some tests failed");
			$finish;
		end
	end

	// Drives one request and returns at the edge of its transfer. The sender
	// works in bursts with random gaps between them.
	task automatic send_item(iwst_pkg::op_t op, logic [31:0] chunk, logic [63:0] sync,
		logic [31:0] b, logic [31:0] e, logic [31:0] id);
		logic rdy;
		if (burst_left == 0) begin
			item_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
			burst_left = $urandom_range(1, 12);
		end
		burst_left--;
		item_ch.valid <= 1'b1;
		item_ch.op <= op;
		item_ch.chunk <= chunk;
		item_ch.sync_tag <= sync;
		item_ch.range_begin <= b;
		item_ch.range_end <= e;
		item_ch.target_id <= id;
		case (op)
			iwst_pkg::OP_PUSH: pushes_sent++;
			iwst_pkg::OP_POP: pops_sent++;
			iwst_pkg::OP_QUERY: queries_sent++;
			default: ;
		endcase
		do begin
			@(negedge clk);
			rdy = item_ch.ready;
			@(posedge clk);
		end while (!rdy);
	endtask

	function automatic logic [63:0] rand_sync();
		return {$urandom, $urandom};
	endfunction

	function automatic logic [31:0] recent_id();
		if ($urandom_range(0, 9) == 0)
			return $urandom;
		return pushes_sent - $urandom_range(0, 40);
	endfunction

	// A push of random shape: mostly small ranges on few chunks.
	task automatic random_push();
		logic [31:0] chunk;
		logic [31:0] b;
		logic [31:0] e;
		chunk = ($urandom_range(0, 9) == 0) ? $urandom : $urandom_range(0, 3);
		b = $urandom_range(0, 60);
		case ($urandom_range(0, 19))
			0: e = b - $urandom_range(0, 3);
			1: begin
				b = $urandom;
				e = $urandom;
			end
			default: e = b + $urandom_range(1, 14);
		endcase
		send_item(iwst_pkg::OP_PUSH, chunk, rand_sync(), b, e, $urandom);
	endtask

	initial begin
		int sel;
		// Known values on every input from time zero.
		arst_n = 1'b0;
		item_ch.valid = 1'b0;
		item_ch.op = iwst_pkg::OP_NOP;
		item_ch.chunk = '0;
		item_ch.sync_tag = '0;
		item_ch.range_begin = '0;
		item_ch.range_end = '0;
		item_ch.target_id = '0;
		burst_left = 0;
		pushes_sent = 0;
		pops_sent = 0;
		queries_sent = 0;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(posedge clk);

		// Directed: whole removal, front and back trims, splits, empty ranges.
		send_item(iwst_pkg::OP_PUSH, 32'd0, 64'hFFFF_FFFF_FFFF_FFFF, 32'd10, 32'd20, '0);
		send_item(iwst_pkg::OP_PUSH, 32'd0, 64'h0, 32'd0, 32'd5, '1);
		send_item(iwst_pkg::OP_PUSH, 32'd0, rand_sync(), 32'd12, 32'd15, '0);
		send_item(iwst_pkg::OP_PUSH, 32'd0, rand_sync(), 32'd8, 32'd12, '0);
		send_item(iwst_pkg::OP_PUSH, 32'd0, rand_sync(), 32'd14, 32'd17, '0);
		send_item(iwst_pkg::OP_QUERY, '0, '0, '0, '0, 32'd0);
		send_item(iwst_pkg::OP_POP, '0, '0, '0, '0, 32'd0);
		send_item(iwst_pkg::OP_PUSH, 32'd0, rand_sync(), 32'd0, 32'd32, '0);
		send_item(iwst_pkg::OP_PUSH, 32'd1, rand_sync(), 32'd7, 32'd7, '0);
		send_item(iwst_pkg::OP_PUSH, 32'd1, rand_sync(), 32'd9, 32'd3, '0);
		send_item(iwst_pkg::OP_PUSH, 32'd1, rand_sync(), 32'd0, 32'd10, '0);
		send_item(iwst_pkg::OP_PUSH, 32'hFFFF_FFFF, 64'hA5A5_5A5A_0F0F_F0F0, 32'hFFFF_FF00,
			32'hFFFF_FFFF, '0);
		send_item(iwst_pkg::OP_PUSH, 32'hFFFF_FFFF, rand_sync(), 32'h0, 32'hFFFF_FFFF, '0);
		send_item(iwst_pkg::OP_QUERY, '0, '0, '0, '0, 32'hFFFF_FFFF);
		send_item(iwst_pkg::OP_POP, '0, '0, '0, '0, 32'hFFFF_FFFF);
		send_item(iwst_pkg::OP_POP, '0, '0, '0, '0, 32'd12);
		send_item(iwst_pkg::OP_POP, '0, '0, '0, '0, 32'd12);
		send_item(iwst_pkg::OP_NOP, '1, '1, '1, '1, '1);

		// Fill the request table until pushes are refused, then drain it.
		for (int i = 0; i < 34; i++)
			send_item(iwst_pkg::OP_PUSH, 32'd100 + i, rand_sync(), 32'd0, 32'd4, '0);
		for (int i = 0; i < 36; i++)
			send_item(iwst_pkg::OP_POP, '0, '0, '0, '0, pushes_sent - i);

		// Random mix, weighted toward pushes that overlap each other.
		for (int n = 0; n < 142; n++) begin
			sel = $urandom_range(0, 99);
			if (sel < 55)
				random_push();
			else if (sel < 80)
				send_item(iwst_pkg::OP_POP, '0, '0, '0, '0, recent_id());
			else if (sel < 96)
				send_item(iwst_pkg::OP_QUERY, '0, '0, '0, '0, recent_id());
			else
				send_item(iwst_pkg::OP_NOP, $urandom, rand_sync(), $urandom, $urandom,
					$urandom);
		end
		item_ch.valid <= 1'b0;

		while (pending_count != 0)
			@(posedge clk);
		repeat (300) @(posedge clk);

		$display("Drove %0d pushes, %0d pops and %0d queries; %0d results were checked.",
			pushes_sent, pops_sent, queries_sent, checked_count);
		if (fail_count == 0 && pending_count == 0) begin
			$display("All tests passed");
		end else begin
			$display("%0d failures, %0d results still expected", fail_count, pending_count);
			$display("Some tests failed");
		end
		$finish;
	end

endmodule
